>>> hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition implies another in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> hw/rtl/ffha_pkg.sv
`default_nettype none

package ffha_pkg;

  // Heap and table geometry
  localparam int unsigned HeapBytes   = 65536;
  localparam int unsigned MaxBlocks   = 64;
  localparam int unsigned HeaderBytes = 16;

  // Derived widths
  localparam int unsigned AddrW = 16;
  localparam int unsigned IdxW  = $clog2(MaxBlocks);
  localparam int unsigned CntW  = $clog2(MaxBlocks + 1);
  localparam int unsigned TopW  = $clog2(HeapBytes + 1);
  localparam int unsigned NeedW = TopW + 1;
  localparam int unsigned EntW  = 2 * AddrW;

  // Request modes
  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StIgnored = 2'd1,
    StNoSpace = 2'd2,
    StUnknown = 2'd3
  } status_e;

  typedef struct packed {
    logic             mode;
    logic [AddrW-1:0] request_size;
    logic [AddrW-1:0] data_address;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] result_address;
    status_e          status;
    logic             reused;
  } rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/ffha_ram.sv
`default_nettype none

module ffha_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write one entry and register one read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hw/rtl/first_fit_heap_allocator_unit.sv
`default_nettype none
`include "assert_macros.svh"

// First-fit heap allocator: keeps an address-ordered table of heap blocks
// (start, size, free mark) plus a heap top, without splitting or merging.
// Channels: a request item (req_i) is taken at a rising edge with start high
// and busy low. The result item (rsp_o) shows for exactly one cycle with
// done_o high; the receiver must take it then and cannot hold it off.
// A zero-size allocate or a null free answers in the next cycle without
// raising busy. Any other request walks the table one entry per cycle
// through the registered read port of the table RAM; busy stays high until
// an entry hits or the table is exhausted, and done_o rises in the same
// cycle that busy falls. One request is handled at a time. A new request
// may be accepted in the cycle the previous result shows. One shared
// subtractor does the entry size and data address compares.
// Reset empties the table and zeroes the heap top; the RAM contents are not
// cleared since only entries below the block count are ever read.
module first_fit_heap_allocator_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire ffha_pkg::req_t req_i,
  output logic             done_o,
  output ffha_pkg::rsp_t   rsp_o
);

  typedef enum logic [1:0] {
    StateIdle = 2'b01,
    StateScan = 2'b10
  } state_e;

  state_e                           state_q, state_d;
  logic [ffha_pkg::CntW-1:0]        idx_q, idx_d;
  logic [ffha_pkg::IdxW-1:0]        chk_q, chk_d;
  logic                             pend_q, pend_d;
  logic [ffha_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic [ffha_pkg::TopW-1:0]        top_q, top_d;
  logic [ffha_pkg::MaxBlocks-1:0]   free_q, free_d;
  logic                             done_q, done_d;
  ffha_pkg::rsp_t                   rsp_q, rsp_d;
  ffha_pkg::req_t                   req_q;

  logic                             accept;
  logic                             ram_we;
  logic [ffha_pkg::IdxW-1:0]        ram_waddr;
  logic [ffha_pkg::EntW-1:0]        ram_wdata;
  logic [ffha_pkg::EntW-1:0]        ram_rdata;
  logic [ffha_pkg::AddrW-1:0]       ent_start;
  logic [ffha_pkg::AddrW-1:0]       ent_size;

  logic [ffha_pkg::TopW-1:0]        op_a, op_b;
  logic [ffha_pkg::TopW:0]          diff;
  logic                             cmp_ge, cmp_eq, hit;
  logic [ffha_pkg::NeedW-1:0]       need;
  logic                             no_space;

  assign accept = start && !busy;
  assign busy   = (state_q == StateScan);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assign ent_start = ram_rdata[ffha_pkg::EntW-1:ffha_pkg::AddrW];
  assign ent_size  = ram_rdata[ffha_pkg::AddrW-1:0];

  // Table RAM: start offset in the upper half, size in the lower half
  ffha_ram #(
    .Width (ffha_pkg::EntW),
    .Depth (ffha_pkg::MaxBlocks)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[ffha_pkg::IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Shared compare unit: size >= request on allocate, data offset == address on free
  always_comb begin
    if (req_q.mode == ffha_pkg::ModeFree) begin
      op_a = {1'b0, ent_start} + ffha_pkg::TopW'(ffha_pkg::HeaderBytes);
      op_b = {1'b0, req_q.data_address};
    end else begin
      op_a = {1'b0, ent_size};
      op_b = {1'b0, req_q.request_size};
    end
    diff   = {1'b0, op_a} - {1'b0, op_b};
    cmp_ge = !diff[ffha_pkg::TopW];
    cmp_eq = (diff == '0);
    hit    = (req_q.mode == ffha_pkg::ModeFree) ? cmp_eq : (free_q[chk_q] && cmp_ge);
  end

  // Space needed to append a new block at the heap top
  assign need = {1'b0, top_q} + ffha_pkg::NeedW'(ffha_pkg::HeaderBytes)
              + ffha_pkg::NeedW'(req_q.request_size);
  assign no_space = (cnt_q >= ffha_pkg::CntW'(ffha_pkg::MaxBlocks))
                 || (need > ffha_pkg::NeedW'(ffha_pkg::HeapBytes));

  // Sequencer: answer a zero-size allocate or null free from idle, else walk the table one entry per cycle, then settle
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    chk_d     = chk_q;
    pend_d    = pend_q;
    cnt_d     = cnt_q;
    top_d     = top_q;
    free_d    = free_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_waddr = cnt_q[ffha_pkg::IdxW-1:0];
    ram_wdata = {top_q[ffha_pkg::AddrW-1:0], req_q.request_size};

    unique case (state_q)
      StateIdle: begin
        if (accept) begin
          if ((req_i.mode == ffha_pkg::ModeAlloc && req_i.request_size == '0) ||
              (req_i.mode == ffha_pkg::ModeFree && req_i.data_address == '0)) begin
            done_d = 1'b1;
            rsp_d  = '{result_address: '0, status: ffha_pkg::StIgnored, reused: 1'b0};
          end else begin
            state_d = StateScan;
            idx_d   = '0;
            pend_d  = 1'b0;
          end
        end
      end
      StateScan: begin
        if (pend_q && hit) begin
          // settle a hit on the entry just read
          state_d = StateIdle;
          done_d  = 1'b1;
          if (req_q.mode == ffha_pkg::ModeFree) begin
            rsp_d = '{result_address: '0, status: ffha_pkg::StOk, reused: 1'b0};
            if (ffha_pkg::CntW'(chk_q) + ffha_pkg::CntW'(1) == cnt_q) begin
              top_d         = {1'b0, ent_start};
              free_d[chk_q] = 1'b0;
              cnt_d         = cnt_q - ffha_pkg::CntW'(1);
            end else begin
              free_d[chk_q] = 1'b1;
            end
          end else begin
            free_d[chk_q] = 1'b0;
            rsp_d = '{result_address: ent_start + ffha_pkg::AddrW'(ffha_pkg::HeaderBytes),
                      status: ffha_pkg::StOk, reused: 1'b1};
          end
        end else if (idx_q < cnt_q) begin
          // issue the next table read
          chk_d  = idx_q[ffha_pkg::IdxW-1:0];
          idx_d  = idx_q + ffha_pkg::CntW'(1);
          pend_d = 1'b1;
        end else if (pend_q) begin
          // drop the last entry, nothing left to issue
          pend_d = 1'b0;
        end else begin
          // table exhausted without a hit
          state_d = StateIdle;
          done_d  = 1'b1;
          if (req_q.mode == ffha_pkg::ModeFree) begin
            rsp_d = '{result_address: '0, status: ffha_pkg::StUnknown, reused: 1'b0};
          end else if (no_space) begin
            rsp_d = '{result_address: '0, status: ffha_pkg::StNoSpace, reused: 1'b0};
          end else begin
            ram_we             = 1'b1;
            free_d[ram_waddr]  = 1'b0;
            cnt_d              = cnt_q + ffha_pkg::CntW'(1);
            top_d              = need[ffha_pkg::TopW-1:0];
            rsp_d = '{result_address: top_q[ffha_pkg::AddrW-1:0]
                                      + ffha_pkg::AddrW'(ffha_pkg::HeaderBytes),
                      status: ffha_pkg::StOk, reused: 1'b0};
          end
        end
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateIdle;
      idx_q   <= '0;
      chk_q   <= '0;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
      top_q   <= '0;
      free_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      chk_q   <= chk_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      top_q   <= top_d;
      free_q  <= free_d;
      done_q  <= done_d;
    end
  end

  // Payload: hold the request and the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  `ASSERT_CLK(a_cnt_bound, clk_i, rst_ni, cnt_q <= ffha_pkg::CntW'(ffha_pkg::MaxBlocks), "block count beyond table depth")
  `ASSERT_CLK(a_top_bound, clk_i, rst_ni, top_q <= ffha_pkg::TopW'(ffha_pkg::HeapBytes), "heap top beyond heap size")
  `ASSERT_CLK(a_scan_done, clk_i, rst_ni, $fell(busy) |-> done_q, "scan ended without a result")
  `ASSERT_NEXT(a_no_done_busy, clk_i, rst_ni, busy && !done_d, !done_q, "result strobe while scanning")

endmodule

`default_nettype wire
